// ===== rtl/core/point_in_obstacle_test_defines.svh =====
// Assertion macros shared by the point-in-obstacle test block.
`ifndef POINT_IN_OBSTACLE_TEST_DEFINES_SVH
`define POINT_IN_OBSTACLE_TEST_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PIO_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PIO_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/core/pio_pkg.sv =====
// Package with the types, constants and tables of the point-in-obstacle test.
`default_nettype none
package pio_pkg;

   localparam int MAX_ARCS = 64;
   localparam int ADDR_W   = $clog2(MAX_ARCS);
   localparam int CNT_W    = $clog2(MAX_ARCS + 1);
   localparam int GEO_W    = 64;
   localparam int SEC_W    = 48;
   localparam int CORDIC_N = 15;
   localparam int CX_W     = 34;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_SEG    = 2'd1;
   localparam logic [1:0] CMD_SECTOR = 2'd2;
   localparam logic [1:0] CMD_QUERY  = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic [14:0]        radius;
      logic [15:0]        angle_start;
      logic [15:0]        angle_end;
      logic signed [15:0] px;
      logic signed [15:0] py;
   } pio_req_type;

   typedef struct packed {
      logic       status;
      logic       inside_res;
      logic [6:0] crossings;
   } pio_rsp_type;

   // Flags that travel alongside one piece through the evaluation pipeline.
   typedef struct packed {
      logic        sec;
      logic        cond;
      logic        dy_pos;
      logic        seg_hit;
      logic        in_rad;
      logic [15:0] a0;
      logic [15:0] a1;
   } pio_stage_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESP
   } pio_state_type;

   // Arctangent of 2^-i in 1/65536 turn units.
   function automatic logic [15:0] atan_units(input int i);
      logic [15:0] r;
      unique case (i)
         0:  r = 16'd8192;
         1:  r = 16'd4836;
         2:  r = 16'd2555;
         3:  r = 16'd1297;
         4:  r = 16'd651;
         5:  r = 16'd326;
         6:  r = 16'd163;
         7:  r = 16'd81;
         8:  r = 16'd41;
         9:  r = 16'd20;
         10: r = 16'd10;
         11: r = 16'd5;
         12: r = 16'd3;
         13: r = 16'd1;
         14: r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/point_in_obstacle_test.sv =====
// Top level of the point-in-obstacle test: piece store, query sequencer and response register.
`default_nettype none
// The block keeps an obstacle outline of up to MAX_ARCS pieces, each a line segment or a
// circular sector, in two synchronous memories. Requests arrive on the req_ channel and
// every request yields exactly one response on the rsp_ channel; both use valid and stall.
// A clear or an append needs no walk; its response is loaded into the response register
// at the accepting edge, and such requests can follow in every cycle while no response is stalled.
// An append to a full store is refused and answered with status set.
// A query reads the stored pieces one per cycle from the memories and passes each through
// an 18-stage evaluation pipeline, whose depth is set by the 15 rotation steps of the
// angle unit. The walk ends when the results of all stored pieces have come back (for an
// empty store, at its start), and the response is then registered from the response state;
// the block accepts no further request until the query's response has been registered.
// While the response register holds a result that the receiver stalls, a new request is
// held off, and a finished query waits in its last state until the register is free.
// Reset is synchronous and active high; it empties the store and the response register.
module point_in_obstacle_test (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire pio_pkg::pio_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output pio_pkg::pio_rsp_type      rsp_data
);
   import pio_pkg::*;
`include "point_in_obstacle_test_defines.svh"

   pio_state_type state_ff, state_in;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] rcv_ff, rcv_in;
   logic [6:0]       hits_ff, hits_in;
   logic signed [15:0] px_ff, py_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   pio_rsp_type rsp_data_ff, rsp_data_in;

   logic accept, out_free, full, is_append, wr_en, rd_en, rd_vld_ff, walk_done;
   logic [GEO_W-1:0] geo_wr, geo_rd;
   logic [SEC_W-1:0] sec_wr, sec_rd;
   logic hit_vld, hit;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign full      = cnt_ff == CNT_W'(MAX_ARCS);
   assign is_append = (req_data.cmd == CMD_SEG) || (req_data.cmd == CMD_SECTOR);
   assign walk_done = rcv_ff == cnt_ff;

   // Write data for the store: a sector keeps its centre and zero in the end point slots.
   always_comb begin
      geo_wr = {req_data.ax, req_data.ay, 32'd0};
      sec_wr = '0;
      if (req_data.cmd == CMD_SEG) begin
         geo_wr[31:0] = {req_data.bx, req_data.by};
      end else begin
         sec_wr = {1'b1, req_data.radius, req_data.angle_start, req_data.angle_end};
      end
   end

   pio_ram #(.WIDTH(GEO_W), .DEPTH(MAX_ARCS)) u_geo_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (geo_wr),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (geo_rd)
   );

   pio_ram #(.WIDTH(SEC_W), .DEPTH(MAX_ARCS)) u_sec_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (sec_wr),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (sec_rd)
   );

   pio_eval u_eval (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (rd_vld_ff),
      .geo_word (geo_rd),
      .sec_word (sec_rd),
      .px       (px_ff),
      .py       (py_ff),
      .hit_vld  (hit_vld),
      .hit      (hit)
   );

   // Next state of the query sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.cmd == CMD_QUERY)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath controls, counters and the response register's next value.
   always_comb begin
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rcv_in       = rcv_ff;
      hits_in      = hits_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in  = '0;
               rcv_in  = '0;
               hits_in = '0;
               if (req_data.cmd != CMD_QUERY) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  if (req_data.cmd == CMD_CLEAR) begin
                     cnt_in = '0;
                  end else if (is_append && full) begin
                     rsp_data_in.status = 1'b1;
                  end else if (is_append) begin
                     wr_en  = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
            end
         end
         ST_WALK: begin
            if (idx_ff < cnt_ff) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
            if (hit_vld) begin
               rcv_in  = rcv_ff + 1'b1;
               hits_in = hits_ff + 7'(hit);
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = 1'b0;
               rsp_data_in.inside_res = hits_ff[0];
               rsp_data_in.crossings  = hits_ff;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rcv_ff       <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rcv_ff       <= rcv_in;
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         px_ff <= req_data.px;
         py_ff <= req_data.py;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The store never holds more pieces than it has room for.
   `PIO_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(MAX_ARCS), "piece count overflow")
   // A query never receives more piece results than it issued reads.
   `PIO_ASSERT_IMPL(a_rcv_bound, state_ff == ST_WALK, rcv_ff <= idx_ff, "stray piece result")
   // An accepted query starts the walk over the store.
   `PIO_ASSERT_NEXT(a_query_walk, accept && (req_data.cmd == CMD_QUERY),
                    state_ff == ST_WALK, "query did not start walking")
   // A new response appears only from an accepted request or a finished query.
   `PIO_ASSERT_IMPL(a_rsp_src, $rose(rsp_valid_ff),
                    $past(state_ff) == ST_IDLE || $past(state_ff) == ST_RESP,
                    "response without source")

endmodule
`default_nettype wire

// ===== rtl/core/pio_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pio_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/pio_eval.sv =====
// Pipelined crossing test of one stored piece per cycle against the query point.
`default_nettype none
module pio_eval (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_vld,
   input  wire logic [pio_pkg::GEO_W-1:0]   geo_word,
   input  wire logic [pio_pkg::SEC_W-1:0]   sec_word,
   input  wire logic signed [15:0]          px,
   input  wire logic signed [15:0]          py,
   output logic                             hit_vld,
   output logic                             hit
);
   import pio_pkg::*;

   localparam int LAST = CORDIC_N + 2;

   logic signed [15:0] ax, ay, bx, by;
   logic signed [16:0] dx_in, dy_in, sdy_in, sbx_in;
   pio_stage_type      st_in, st3_in;

   logic               vld_ff [1:LAST];
   pio_stage_type      st_ff  [1:LAST];

   logic signed [16:0] dx1_ff, dy1_ff, sdy1_ff, sbx1_ff;
   logic [14:0]        rad1_ff;

   logic signed [33:0] lhs2_ff, rhs2_ff, sqx2_ff, sqy2_ff;
   logic [29:0]        rr2_ff;
   logic [33:0]        dist_sum;

   logic signed [CX_W-1:0] cx_ff [0:CORDIC_N];
   logic signed [CX_W-1:0] cy_ff [0:CORDIC_N];
   logic [15:0]            cz_ff [0:CORDIC_N];
   logic signed [CX_W-1:0] cx_in [0:CORDIC_N];
   logic signed [CX_W-1:0] cy_in [0:CORDIC_N];
   logic [15:0]            cz_in [0:CORDIC_N];
   logic signed [16:0]     xa, ya;

   logic hit_vld_ff, hit_ff, hit_in;

   assign ax = signed'(geo_word[63:48]);
   assign ay = signed'(geo_word[47:32]);
   assign bx = signed'(geo_word[31:16]);
   assign by = signed'(geo_word[15:0]);

   always_comb begin
      dx_in  = {px[15], px} - {ax[15], ax};
      dy_in  = {py[15], py} - {ay[15], ay};
      sdy_in = {by[15], by} - {ay[15], ay};
      sbx_in = {bx[15], bx} - {ax[15], ax};
      st_in.sec     = sec_word[47];
      st_in.cond    = (ay > py) != (by > py);
      st_in.dy_pos  = ~sdy_in[16];
      st_in.seg_hit = 1'b0;
      st_in.in_rad  = 1'b0;
      st_in.a0      = sec_word[31:16];
      st_in.a1      = sec_word[15:0];
   end

   // Products of stage two feed the segment and radius compares of stage three.
   always_comb begin
      dist_sum = 34'(unsigned'(sqx2_ff[32:0])) + 34'(unsigned'(sqy2_ff[32:0]));
      st3_in = st_ff[2];
      st3_in.seg_hit = st_ff[2].cond &&
                       (st_ff[2].dy_pos ? (lhs2_ff < rhs2_ff) : (lhs2_ff > rhs2_ff));
      st3_in.in_rad  = dist_sum <= 34'(rr2_ff);
   end

   // Rotation of the direction vector onto the positive x axis.
   always_comb begin
      xa = dx1_ff[16] ? -dx1_ff : dx1_ff;
      ya = dx1_ff[16] ? -dy1_ff : dy1_ff;
      cx_in[0] = CX_W'(xa) <<< 14;
      cy_in[0] = CX_W'(ya) <<< 14;
      cz_in[0] = dx1_ff[16] ? 16'h8000 : 16'h0000;
      for (int k = 0; k < CORDIC_N; k++) begin
         if (cy_ff[k] > 0) begin
            cx_in[k+1] = cx_ff[k] + (cy_ff[k] >>> k);
            cy_in[k+1] = cy_ff[k] - (cx_ff[k] >>> k);
            cz_in[k+1] = cz_ff[k] + atan_units(k);
         end else if (cy_ff[k] < 0) begin
            cx_in[k+1] = cx_ff[k] - (cy_ff[k] >>> k);
            cy_in[k+1] = cy_ff[k] + (cx_ff[k] >>> k);
            cz_in[k+1] = cz_ff[k] - atan_units(k);
         end else begin
            cx_in[k+1] = cx_ff[k];
            cy_in[k+1] = cy_ff[k];
            cz_in[k+1] = cz_ff[k];
         end
      end
   end

   always_comb begin
      if (st_ff[LAST].sec) begin
         hit_in = st_ff[LAST].in_rad && (st_ff[LAST].a0 <= cz_ff[CORDIC_N]) &&
                  (cz_ff[CORDIC_N] <= st_ff[LAST].a1);
      end else begin
         hit_in = st_ff[LAST].seg_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LAST; k++) begin
            vld_ff[k] <= 1'b0;
         end
         hit_vld_ff <= 1'b0;
      end else begin
         vld_ff[1] <= in_vld;
         for (int k = 2; k <= LAST; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         hit_vld_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      st_ff[1] <= st_in;
      st_ff[2] <= st_ff[1];
      st_ff[3] <= st3_in;
      for (int k = 4; k <= LAST; k++) begin
         st_ff[k] <= st_ff[k-1];
      end
      dx1_ff  <= dx_in;
      dy1_ff  <= dy_in;
      sdy1_ff <= sdy_in;
      sbx1_ff <= sbx_in;
      rad1_ff <= sec_word[46:32];
      lhs2_ff <= 34'(dx1_ff) * 34'(sdy1_ff);
      rhs2_ff <= 34'(sbx1_ff) * 34'(dy1_ff);
      sqx2_ff <= 34'(dx1_ff) * 34'(dx1_ff);
      sqy2_ff <= 34'(dy1_ff) * 34'(dy1_ff);
      rr2_ff  <= 30'(rad1_ff) * 30'(rad1_ff);
      for (int k = 0; k <= CORDIC_N; k++) begin
         cx_ff[k] <= cx_in[k];
         cy_ff[k] <= cy_in[k];
         cz_ff[k] <= cz_in[k];
      end
      hit_ff <= hit_in;
   end

   assign hit_vld = hit_vld_ff;
   assign hit     = hit_ff;

endmodule
`default_nettype wire
